[src/gfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfp_pkg: shared types and constants for the GF(2^64) fixed-base power block
// Field arithmetic helpers and the status codes used by the block.
// ----------------------------------------------------------------------------
package gfp_pkg;
   localparam int          DigitBitsDefault = 8;
   localparam logic [63:0] BaseReset        = 64'h967A2A6581F71CAD;

   localparam logic [1:0] STATUS_BUILT     = 2'd0;
   localparam logic [1:0] STATUS_VALID     = 2'd1;
   localparam logic [1:0] STATUS_NOT_BUILT = 2'd2;

   typedef struct packed {
      logic        action;
      logic [63:0] exponent;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [63:0] power_value;
   } rsp_type;

   // Reduction of a 128-bit carry-less product modulo x^64+x^4+x^3+x+1.
   function automatic logic [63:0] gf_reduce(input logic [127:0] prod);
      logic [63:0] h;
      logic [63:0] t;
      h = prod[127:64];
      t = h ^ (h >> 60) ^ (h >> 61) ^ (h >> 63);
      return prod[63:0] ^ t ^ (t << 1) ^ (t << 3) ^ (t << 4);
   endfunction
endpackage
`default_nettype wire

[src/gfp_stream_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfp_stream_if: valid/ready channel
// Carries one payload per transfer between a source and a sink.
// ----------------------------------------------------------------------------
interface gfp_stream_if #(parameter int Width = 1);
   logic             valid;
   logic             ready;
   logic [Width-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/gfp_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gfp_ram: generic single-port RAM
// One address per cycle, written when enabled and always read; read data is registered.
// ----------------------------------------------------------------------------
module gfp_ram #(
   parameter int Width = 64,
   parameter int Depth = 2048
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] addr,
   input  wire logic [Width-1:0]         wr_data,
   output      logic [Width-1:0]         rd_data_ff
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule
`default_nettype wire

[src/gf64_fixed_base_power.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gf64_fixed_base_power: fixed-base exponentiation in GF(2^64)
// Builds digit power tables from a base and raises it to 64-bit exponents.
// ----------------------------------------------------------------------------
// A build request (action 0) fills the power table from the base element
// register: DIGIT_COUNT rows of 2^DIGIT_BITS entries, each entry the previous
// one times the row step, then the step is squared DIGIT_BITS times for the
// next row. One shared carry-less multiplier does all the work. For each
// product the raw product is first registered in the product register and
// then reduced. An exponentiate request (action 1) reads one table entry per
// digit from the single RAM port and multiplies it into an accumulator,
// reading, multiplying and reducing for each digit. Exponentiating before
// any build answers status 2. The block takes one request at a time; the
// response sits in an output register until the sink takes the transfer,
// so back-pressure on the response also holds off the next request.
module gf64_fixed_base_power
   import gfp_pkg::*;
#(
   parameter int DIGIT_BITS = DigitBitsDefault
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_wr_en,
   input  wire logic [63:0] csr_wr_data,
   gfp_stream_if.sink       req,
   gfp_stream_if.source     rsp
);
   localparam int DigitCount = (64 + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int DigitVals  = 1 << DIGIT_BITS;
   localparam int Depth      = DigitCount * DigitVals;
   localparam int AddrW      = $clog2(Depth);
   localparam int PosW       = $clog2(DigitCount + 1);
   localparam int SqW        = $clog2(DIGIT_BITS + 1);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;  // product register loaded
   localparam logic [2:0] ST_RED  = 3'd2;  // reduced result ready
   localparam logic [2:0] ST_RD   = 3'd3;  // table read in flight
   localparam logic [2:0] ST_OUT  = 3'd4;

   localparam logic [1:0] OP_ROW = 2'd0;
   localparam logic [1:0] OP_SQ  = 2'd1;
   localparam logic [1:0] OP_EXP = 2'd2;

   req_type req_payload;
   rsp_type rsp_ff, rsp_in;
   assign req_payload = req.data;
   assign rsp.data    = rsp_ff;

   logic [2:0]        state_ff, state_in;
   logic [1:0]        op_ff, op_in;
   logic              ready_ff, ready_in;
   logic [63:0]       base_ff, base_in;
   logic [63:0]       step_ff, step_in;
   logic [63:0]       acc_ff, acc_in;
   logic [63:0]       exp_ff, exp_in;
   logic [PosW-1:0]   pos_ff, pos_in;
   logic [DIGIT_BITS:0] j_ff, j_in;
   logic [SqW-1:0]    sq_ff, sq_in;
   logic [127:0]      prod_ff, prod_in;
   logic [63:0]       mul_a, mul_b;

   logic              ram_we;
   logic [AddrW-1:0]  ram_addr;
   logic [63:0]       ram_wdata, ram_rdata;

   gfp_ram #(.Width(64), .Depth(Depth)) u_ram (
      .clock      (clock),
      .wr_en      (ram_we),
      .addr       (ram_addr),
      .wr_data    (ram_wdata),
      .rd_data_ff (ram_rdata)
   );

   // Shared 64x64 carry-less multiplier, registered before reduction.
   always_comb begin
      prod_in = '0;
      for (int b = 0; b < 64; b++) begin
         if (mul_b[b]) begin
            prod_in = prod_in ^ ({64'd0, mul_a} << b);
         end
      end
   end

   logic [63:0] red;
   assign red = gf_reduce(prod_ff);

   logic [DIGIT_BITS-1:0] digit;
   assign digit = exp_ff[DIGIT_BITS-1:0];

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      ready_in  = ready_ff;
      base_in   = csr_wr_en ? csr_wr_data : base_ff;
      step_in   = step_ff;
      acc_in    = acc_ff;
      exp_in    = exp_ff;
      pos_in    = pos_ff;
      j_in      = j_ff;
      sq_in     = sq_ff;
      rsp_in    = rsp_ff;
      mul_a     = acc_ff;
      mul_b     = step_ff;
      ram_we    = 1'b0;
      ram_wdata = acc_ff;
      ram_addr  = AddrW'(pos_ff * DigitVals) + AddrW'(j_ff[DIGIT_BITS-1:0]);
      unique case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               if (!req_payload.action) begin
                  // Row start: entry 0 is one.
                  step_in   = base_ff;
                  acc_in    = 64'd1;
                  pos_in    = '0;
                  j_in      = (DIGIT_BITS+1)'(1);
                  ram_we    = 1'b1;
                  ram_wdata = 64'd1;
                  ram_addr  = '0;
                  op_in     = OP_ROW;
                  state_in  = ST_MUL;
               end else if (!ready_ff) begin
                  rsp_in   = '{status: STATUS_NOT_BUILT, power_value: 64'd0};
                  state_in = ST_OUT;
               end else begin
                  acc_in   = 64'd1;
                  exp_in   = req_payload.exponent;
                  pos_in   = '0;
                  op_in    = OP_EXP;
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: begin
            ram_addr = AddrW'(pos_ff * DigitVals) + AddrW'(digit);
            state_in = ST_MUL;
         end
         ST_MUL: begin
            // Product of the operands selected by the operation.
            unique case (op_ff)
               OP_ROW: begin mul_a = step_ff; mul_b = acc_ff; end
               OP_SQ:  begin mul_a = step_ff; mul_b = step_ff; end
               default: begin mul_a = acc_ff; mul_b = ram_rdata; end
            endcase
            state_in = ST_RED;
         end
         ST_RED: begin
            unique case (op_ff)
               OP_ROW: begin
                  acc_in    = red;
                  ram_we    = 1'b1;
                  ram_wdata = red;
                  if (j_ff == (DIGIT_BITS+1)'(DigitVals - 1)) begin
                     op_in = OP_SQ;
                     sq_in = '0;
                  end
                  j_in     = j_ff + 1'b1;
                  state_in = ST_MUL;
               end
               OP_SQ: begin
                  step_in = red;
                  if (sq_ff == SqW'(DIGIT_BITS - 1)) begin
                     if (pos_ff == PosW'(DigitCount - 1)) begin
                        ready_in = 1'b1;
                        rsp_in   = '{status: STATUS_BUILT, power_value: 64'd0};
                        state_in = ST_OUT;
                     end else begin
                        pos_in    = pos_ff + 1'b1;
                        ram_we    = 1'b1;
                        ram_wdata = 64'd1;
                        ram_addr  = AddrW'((pos_ff + 1'b1) * DigitVals);
                        acc_in    = 64'd1;
                        j_in      = (DIGIT_BITS+1)'(1);
                        op_in     = OP_ROW;
                        state_in  = ST_MUL;
                     end
                  end else begin
                     sq_in    = sq_ff + 1'b1;
                     state_in = ST_MUL;
                  end
               end
               default: begin
                  acc_in = red;
                  exp_in = exp_ff >> DIGIT_BITS;
                  if (pos_ff == PosW'(DigitCount - 1)) begin
                     rsp_in   = '{status: STATUS_VALID, power_value: red};
                     state_in = ST_OUT;
                  end else begin
                     pos_in   = pos_ff + 1'b1;
                     state_in = ST_RD;
                  end
               end
            endcase
         end
         ST_OUT: begin
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req.ready = (state_ff == ST_IDLE);
   assign rsp.valid = (state_ff == ST_OUT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b0;
         base_ff  <= BaseReset;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
         base_ff  <= base_in;
      end
      op_ff   <= op_in;
      step_ff <= step_in;
      acc_ff  <= acc_in;
      exp_ff  <= exp_in;
      pos_ff  <= pos_in;
      j_ff    <= j_in;
      sq_ff   <= sq_in;
      prod_ff <= prod_in;
      rsp_ff  <= rsp_in;
   end

   // A not-built answer never follows a finished build.
   a_not_built_only_before_build: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && ready_ff) |-> (rsp_ff.status != STATUS_NOT_BUILT))
      else $error("not-built status after tables were built");
   a_value_zero_unless_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp_ff.status != STATUS_VALID) |-> (rsp_ff.power_value == 64'd0))
      else $error("nonzero power value without valid status");
   a_out_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> (rsp.valid && $stable(rsp_ff)))
      else $error("response changed while stalled");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready)
      else $error("request ready while busy");
endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking testbench for gf64_fixed_base_power
// Fills a queue of build and exponentiate requests. A clocked driver sends
// them with random gaps, and a clocked monitor takes responses under random
// back-pressure. Each accepted request is predicted by an in-bench model of
// the GF(2^64) power tables, and every response is compared field by field.
// ----------------------------------------------------------------------------
module tb
   import gfp_pkg::*;
();

   localparam int DigitBits   = DigitBitsDefault;
   localparam int DigitCount  = (64 + DigitBits - 1) / DigitBits;
   localparam int DigitValues = 1 << DigitBits;
   localparam int CycleLimit  = 2000000;
   localparam logic ActBuild  = 1'b0;
   localparam logic ActPower  = 1'b1;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_wr_en = 1'b0;
   logic [63:0] csr_wr_data = '0;

   gfp_stream_if #(.Width($bits(req_type))) req_if ();
   gfp_stream_if #(.Width($bits(rsp_type))) rsp_if ();

   gf64_fixed_base_power DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req         (req_if),
      .rsp         (rsp_if)
   );

   always #5 clock = ~clock;

   // Requests waiting to be sent, and responses that the power model expects.
   req_type pending_reqs[$];
   rsp_type expected_rsps[$];

   // Shadow of the block's state: base register, power tables, ready flag.
   logic [63:0] base_shadow;
   logic [63:0] power_rows[DigitCount][DigitValues];
   logic tables_built;

   int error_count = 0;
   int builds_seen = 0;
   int powers_seen = 0;
   int unbuilt_seen = 0;
   int cycle_count = 0;
   // Percent of cycles in which the sender and the receiver hold off.
   int send_idle_pct = 29;
   int take_idle_pct = 86;

   // Carry-less 64x64 product, then the two folds modulo x^64+x^4+x^3+x+1.
   function automatic logic [63:0] field_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      logic [63:0] hi;
      logic [63:0] fold;
      prod = '0;
      for (int i = 0; i < 64; i++) begin
         if (b[i]) begin
            prod = prod ^ ({64'd0, a} << i);
         end
      end
      hi = prod[127:64];
      fold = hi ^ (hi >> 60) ^ (hi >> 61) ^ (hi >> 63);
      return prod[63:0] ^ fold ^ (fold << 1) ^ (fold << 3) ^ (fold << 4);
   endfunction

   // Each row holds the powers of its step; the next step is the current one
   // squared DigitBits times.
   task automatic fill_power_rows();
      logic [63:0] row_step;
      row_step = base_shadow;
      for (int r = 0; r < DigitCount; r++) begin
         power_rows[r][0] = 64'd1;
         for (int j = 1; j < DigitValues; j++) begin
            power_rows[r][j] = field_mul(row_step, power_rows[r][j-1]);
         end
         for (int s = 0; s < DigitBits; s++) begin
            row_step = field_mul(row_step, row_step);
         end
      end
      tables_built = 1'b1;
   endtask

   function automatic logic [63:0] table_power(input logic [63:0] n);
      logic [63:0] acc;
      logic [63:0] digit;
      acc = 64'd1;
      for (int r = 0; r < DigitCount; r++) begin
         digit = (n >> (r * DigitBits)) & (DigitValues - 1);
         acc = field_mul(acc, power_rows[r][digit]);
      end
      return acc;
   endfunction

   task automatic predict_response(input req_type item);
      rsp_type exp_rsp;
      if (item.action == ActBuild) begin
         fill_power_rows();
         exp_rsp.status = STATUS_BUILT;
         exp_rsp.power_value = '0;
      end else if (!tables_built) begin
         exp_rsp.status = STATUS_NOT_BUILT;
         exp_rsp.power_value = '0;
      end else begin
         exp_rsp.status = STATUS_VALID;
         exp_rsp.power_value = table_power(item.exponent);
      end
      expected_rsps.push_back(exp_rsp);
   endtask

   // Driver: a new request goes out only once the current one has been taken.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         req_if.data <= '0;
      end else if (!req_if.valid || req_if.ready) begin
         if (req_if.valid) begin
            predict_response(req_type'(req_if.data));
         end
         if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_if.valid <= 1'b1;
            req_if.data <= pending_reqs.pop_front();
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // Monitor: random back-pressure, and every transfer is checked.
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= take_idle_pct);
         if (rsp_if.valid && rsp_if.ready) begin
            got = rsp_type'(rsp_if.data);
            if (expected_rsps.size() == 0) begin
               $error("response with no request outstanding: status %0d value %h",
                      got.status, got.power_value);
               error_count++;
            end else begin
               want = expected_rsps.pop_front();
               if (got.status !== want.status) begin
                  $error("status: expected %0d, got %0d", want.status, got.status);
                  error_count++;
               end
               if (got.power_value !== want.power_value) begin
                  $error("power_value: expected %h, got %h",
                         want.power_value, got.power_value);
                  error_count++;
               end
               case (want.status)
                  STATUS_BUILT: builds_seen++;
                  STATUS_VALID: powers_seen++;
                  default: unbuilt_seen++;
               endcase
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic queue_request(input logic act, input logic [63:0] n);
      req_type item;
      item.action = act;
      item.exponent = n;
      pending_reqs.push_back(item);
   endtask

   // Idle means nothing left to send, nothing in flight and nothing owed.
   task automatic wait_quiet();
      do begin
         @(negedge clock);
      end while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0);
   endtask

   // The register only changes while the block is quiet.
   task automatic write_base(input logic [63:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_shadow = value;
   endtask

   // Mix of dense, single-digit, small and digit-saturated exponents.
   function automatic logic [63:0] pick_exponent();
      logic [63:0] n;
      int pos;
      n = {$urandom, $urandom};
      case ($urandom_range(3))
         0: ;
         1: begin
            pos = $urandom_range(DigitCount - 1);
            n = 64'($urandom_range(DigitValues - 1)) << (pos * DigitBits);
         end
         2: n = 64'($urandom_range(300));
         default: begin
            for (int r = 0; r < DigitCount; r++) begin
               if ($urandom_range(2) == 0) begin
                  n = n & ~(64'(DigitValues - 1) << (r * DigitBits));
               end else if ($urandom_range(1) == 0) begin
                  n = n | (64'(DigitValues - 1) << (r * DigitBits));
               end
            end
         end
      endcase
      return n;
   endfunction

   initial begin
      logic [63:0] phase_bases[9];
      base_shadow = BaseReset;
      tables_built = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Exponentiate before any build must answer not-built.
      queue_request(ActPower, 64'd0);
      queue_request(ActPower, '1);
      // Build from the reset base; the exponent field is ignored on a build.
      queue_request(ActBuild, {$urandom, $urandom});
      queue_request(ActPower, 64'd0);
      queue_request(ActPower, 64'd1);
      queue_request(ActPower, 64'd2);
      queue_request(ActPower, '1);
      queue_request(ActPower, 64'h8000_0000_0000_0000);
      queue_request(ActPower, 64'hFF);
      queue_request(ActPower, 64'h0101_0101_0101_0101);
      wait_quiet();

      // A new base does not reach the tables until the next build.
      write_base(64'd0);
      queue_request(ActPower, 64'd5);
      queue_request(ActBuild, 64'd0);
      queue_request(ActPower, 64'd0);
      queue_request(ActPower, 64'd7);
      queue_request(ActPower, '1);
      wait_quiet();
      write_base('1);
      queue_request(ActBuild, '1);
      queue_request(ActPower, 64'd3);
      queue_request(ActPower, '1);
      queue_request(ActPower, 64'h00FF_00FF_00FF_00FF);
      wait_quiet();
      write_base(64'd1);
      queue_request(ActBuild, 64'd0);
      queue_request(ActPower, {$urandom, $urandom});
      wait_quiet();

      // Random phases: three idling patterns, three bases each.
      phase_bases = '{ {$urandom, $urandom}, 64'd2, BaseReset, 64'd0, {$urandom, $urandom},
                       '1, 64'd1, {$urandom, $urandom}, 64'h8000_0000_0000_0000 };
      for (int ph = 0; ph < 9; ph++) begin
         case (ph / 3)
            0: begin send_idle_pct = 29; take_idle_pct = 86; end
            1: begin send_idle_pct = 86; take_idle_pct = 29; end
            default: begin send_idle_pct = 0; take_idle_pct = 0; end
         endcase
         write_base(phase_bases[ph]);
         // Sometimes keep the old tables for a while after the base changes.
         if ($urandom_range(3) != 0) begin
            queue_request(ActBuild, {$urandom, $urandom});
         end
         for (int k = 0; k < 185; k++) begin
            if (k == 90 && $urandom_range(1) == 0) begin
               queue_request(ActBuild, {$urandom, $urandom});
            end
            queue_request(ActPower, pick_exponent());
         end
         wait_quiet();
      end

      repeat (60) @(posedge clock);
      $display("covered %0d builds, %0d powers, %0d requests before any build",
               builds_seen, powers_seen, unbuilt_seen);
      $display("over thirteen base settings and three idling patterns in %0d cycles",
               cycle_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule
